[design/bsm_pkg.sv]
// Package for the bank switch mapper: opcodes, CPU register decode,
// bank selector codes, transaction structs and default-bank helpers.
// No dependencies.
package bsm_pkg;

    localparam int ADDR_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int PRG_SLOTS  = 4;
    localparam int CHR_SLOTS  = 8;
    localparam int PRG_BITS_W = PRG_SLOTS * BYTE_W;
    localparam int CHR_BITS_W = CHR_SLOTS * BYTE_W;

    // item opcodes
    localparam logic [1:0] OP_CPU_WRITE = 2'd0;
    localparam logic [1:0] OP_TICK      = 2'd1;
    localparam logic [1:0] OP_INIT      = 2'd2;

    // CPU register decode, after masking the address
    localparam logic [ADDR_W-1:0] ADDR_MASK        = 16'hE001;
    localparam logic [ADDR_W-1:0] ADDR_BANK_SELECT = 16'h8000;
    localparam logic [ADDR_W-1:0] ADDR_BANK_DATA   = 16'h8001;
    localparam logic [ADDR_W-1:0] ADDR_MIRROR      = 16'hA000;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_COUNT   = 16'hC000;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_LATCH   = 16'hC001;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_DISABLE = 16'hE000;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_ENABLE  = 16'hE001;

    // bank selector codes, after masking bank_select
    localparam logic [BYTE_W-1:0] SEL_MASK      = 8'hC7;
    localparam logic [BYTE_W-1:0] PAIR_MASK     = 8'hFE;
    localparam logic [BYTE_W-1:0] SEL_CHR_PAIR0 = 8'h00;
    localparam logic [BYTE_W-1:0] SEL_CHR_PAIR1 = 8'h01;
    localparam logic [BYTE_W-1:0] SEL_CHR_LO    = 8'h02;
    localparam logic [BYTE_W-1:0] SEL_CHR_HI    = 8'h05;
    localparam logic [BYTE_W-1:0] SEL_PRG0      = 8'h06;
    localparam logic [BYTE_W-1:0] SEL_PRG1      = 8'h07;
    localparam logic [BYTE_W-1:0] SEL_PRG2      = 8'h46;
    localparam logic [BYTE_W-1:0] SEL_PRG3      = 8'h47;
    localparam logic [BYTE_W-1:0] SEL_CHR_PAIR2 = 8'h80;
    localparam logic [BYTE_W-1:0] SEL_CHR_PAIR3 = 8'h81;
    localparam logic [BYTE_W-1:0] SEL_CHR_ALT_LO = 8'h82;
    localparam logic [BYTE_W-1:0] SEL_CHR_ALT_HI = 8'h85;

    localparam logic [BYTE_W-1:0] PRG_ROM_BANKS_RESET = 8'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [ADDR_W-1:0] address;
        logic [BYTE_W-1:0] data;
        logic              in_vblank;
    } t_item;

    typedef struct packed {
        logic [PRG_BITS_W-1:0] prg_banks;
        logic [CHR_BITS_W-1:0] chr_banks;
        logic                  mirror_horizontal;
        logic                  irq_pulse;
    } t_result;

    // last 8KB bank number: 2*banks - 1, wrapping at 256
    function automatic logic [BYTE_W-1:0] last_prg_bank(input logic [BYTE_W-1:0] banks);
        logic [BYTE_W:0] twice;
        twice = {banks, 1'b0};
        return BYTE_W'(twice - 9'd1);
    endfunction

endpackage

[design/bsm_if.sv]
// Valid/ready channel interfaces for the mapper's input items and results.
// Depends on bsm_pkg for field widths.
interface bsm_item_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 opcode;
    logic [bsm_pkg::ADDR_W-1:0] address;
    logic [bsm_pkg::BYTE_W-1:0] data;
    logic                       in_vblank;

    modport source (output valid, output opcode, output address, output data,
                    output in_vblank, input ready);
    modport sink (input valid, input opcode, input address, input data,
                  input in_vblank, output ready);
endinterface

interface bsm_result_if;
    logic                           valid;
    logic                           ready;
    logic [bsm_pkg::PRG_BITS_W-1:0] prg_banks;
    logic [bsm_pkg::CHR_BITS_W-1:0] chr_banks;
    logic                           mirror_horizontal;
    logic                           irq_pulse;

    modport source (output valid, output prg_banks, output chr_banks,
                    output mirror_horizontal, output irq_pulse, input ready);
    modport sink (input valid, input prg_banks, input chr_banks,
                  input mirror_horizontal, input irq_pulse, output ready);
endinterface

[design/bsm_core.sv]
// Mapper state registers and the single-pass update logic for one item.
// Depends on bsm_pkg.
module bsm_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bsm_pkg::BYTE_W-1:0] i_cfg_data,
    input  logic                       i_process,
    input  bsm_pkg::t_item             i_item,
    output bsm_pkg::t_result           o_result
);

    logic [bsm_pkg::BYTE_W-1:0] r_cfg_banks;
    logic [bsm_pkg::BYTE_W-1:0] r_bank_select, n_bank_select;
    logic [bsm_pkg::BYTE_W-1:0] r_prg [bsm_pkg::PRG_SLOTS];
    logic [bsm_pkg::BYTE_W-1:0] n_prg [bsm_pkg::PRG_SLOTS];
    logic [bsm_pkg::BYTE_W-1:0] r_chr [bsm_pkg::CHR_SLOTS];
    logic [bsm_pkg::BYTE_W-1:0] n_chr [bsm_pkg::CHR_SLOTS];
    logic                       r_mirror, n_mirror;
    logic                       r_irq_enabled, n_irq_enabled;
    logic [bsm_pkg::BYTE_W-1:0] r_irq_count, n_irq_count;
    logic [bsm_pkg::BYTE_W-1:0] r_irq_reload, n_irq_reload;

    logic                        pulse;
    logic [bsm_pkg::BYTE_W-1:0]  sel;
    logic [bsm_pkg::BYTE_W-1:0]  pair;
    logic [bsm_pkg::BYTE_W-1:0]  last;
    logic [bsm_pkg::ADDR_W-1:0]  reg_addr;

    assign sel      = r_bank_select & bsm_pkg::SEL_MASK;
    assign pair     = i_item.data & bsm_pkg::PAIR_MASK;
    assign last     = bsm_pkg::last_prg_bank(r_cfg_banks);
    assign reg_addr = i_item.address & bsm_pkg::ADDR_MASK;

    always_comb begin
        n_bank_select = r_bank_select;
        n_prg         = r_prg;
        n_chr         = r_chr;
        n_mirror      = r_mirror;
        n_irq_enabled = r_irq_enabled;
        n_irq_count   = r_irq_count;
        n_irq_reload  = r_irq_reload;
        pulse         = 1'b0;

        case (i_item.opcode)
            bsm_pkg::OP_CPU_WRITE: begin
                case (reg_addr)
                    bsm_pkg::ADDR_BANK_SELECT: n_bank_select = i_item.data;
                    bsm_pkg::ADDR_BANK_DATA: begin
                        case (sel) inside
                            bsm_pkg::SEL_CHR_PAIR0: begin
                                n_chr[0] = pair;
                                n_chr[1] = pair + 8'd1;
                            end
                            bsm_pkg::SEL_CHR_PAIR1: begin
                                n_chr[2] = pair;
                                n_chr[3] = pair + 8'd1;
                            end
                            [bsm_pkg::SEL_CHR_LO:bsm_pkg::SEL_CHR_HI]:
                                n_chr[3'(sel[2:0] + 3'd2)] = i_item.data;
                            bsm_pkg::SEL_PRG0: n_prg[0] = i_item.data;
                            bsm_pkg::SEL_PRG1: n_prg[1] = i_item.data;
                            bsm_pkg::SEL_PRG2: n_prg[2] = i_item.data;
                            bsm_pkg::SEL_PRG3: n_prg[3] = i_item.data;
                            bsm_pkg::SEL_CHR_PAIR2: begin
                                n_chr[4] = pair;
                                n_chr[5] = pair + 8'd1;
                            end
                            bsm_pkg::SEL_CHR_PAIR3: begin
                                n_chr[6] = pair;
                                n_chr[7] = pair + 8'd1;
                            end
                            [bsm_pkg::SEL_CHR_ALT_LO:bsm_pkg::SEL_CHR_ALT_HI]:
                                n_chr[3'(sel[2:0] - 3'd2)] = i_item.data;
                            default: ;
                        endcase
                    end
                    bsm_pkg::ADDR_MIRROR:      n_mirror      = i_item.data[0];
                    bsm_pkg::ADDR_IRQ_COUNT:   n_irq_count   = i_item.data;
                    bsm_pkg::ADDR_IRQ_LATCH:   n_irq_reload  = i_item.data;
                    bsm_pkg::ADDR_IRQ_DISABLE: n_irq_enabled = 1'b0;
                    bsm_pkg::ADDR_IRQ_ENABLE:  n_irq_enabled = 1'b1;
                    default: ;
                endcase
            end
            bsm_pkg::OP_TICK: begin
                if (!i_item.in_vblank && r_irq_enabled) begin
                    if (r_irq_count == '0) begin
                        n_irq_count = r_irq_reload;
                        pulse       = 1'b1;
                    end else begin
                        n_irq_count = r_irq_count - 8'd1;
                    end
                end
            end
            bsm_pkg::OP_INIT: begin
                // mirroring survives init
                n_bank_select = '0;
                n_prg[0]      = 8'd0;
                n_prg[1]      = 8'd1;
                n_prg[2]      = last - 8'd1;
                n_prg[3]      = last;
                for (int i = 0; i < bsm_pkg::CHR_SLOTS; i++) begin
                    n_chr[i] = 8'(i);
                end
                n_irq_enabled = 1'b0;
                n_irq_count   = '0;
                n_irq_reload  = '0;
            end
            default: ;
        endcase
    end

    always_comb begin
        for (int i = 0; i < bsm_pkg::PRG_SLOTS; i++) begin
            o_result.prg_banks[i*bsm_pkg::BYTE_W +: bsm_pkg::BYTE_W] = n_prg[i];
        end
        for (int i = 0; i < bsm_pkg::CHR_SLOTS; i++) begin
            o_result.chr_banks[i*bsm_pkg::BYTE_W +: bsm_pkg::BYTE_W] = n_chr[i];
        end
        o_result.mirror_horizontal = n_mirror;
        o_result.irq_pulse         = pulse;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_banks   <= bsm_pkg::PRG_ROM_BANKS_RESET;
            r_bank_select <= '0;
            r_prg[0]      <= 8'd0;
            r_prg[1]      <= 8'd1;
            r_prg[2]      <= bsm_pkg::last_prg_bank(bsm_pkg::PRG_ROM_BANKS_RESET) - 8'd1;
            r_prg[3]      <= bsm_pkg::last_prg_bank(bsm_pkg::PRG_ROM_BANKS_RESET);
            for (int i = 0; i < bsm_pkg::CHR_SLOTS; i++) begin
                r_chr[i] <= 8'(i);
            end
            r_mirror      <= 1'b0;
            r_irq_enabled <= 1'b0;
            r_irq_count   <= '0;
            r_irq_reload  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_banks <= i_cfg_data;
            end
            if (i_process) begin
                r_bank_select <= n_bank_select;
                r_prg         <= n_prg;
                r_chr         <= n_chr;
                r_mirror      <= n_mirror;
                r_irq_enabled <= n_irq_enabled;
                r_irq_count   <= n_irq_count;
                r_irq_reload  <= n_irq_reload;
            end
        end
    end

`ifndef ASSERT_OFF
    a_pulse_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_process && o_result.irq_pulse) |->
            (i_item.opcode == bsm_pkg::OP_TICK && r_irq_enabled && !i_item.in_vblank))
        else $error("irq pulse without an enabled active tick");

    a_pulse_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_process && o_result.irq_pulse) |=> (r_irq_count == $past(r_irq_reload)))
        else $error("irq counter not reloaded on pulse");

    a_init_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_process && i_item.opcode == bsm_pkg::OP_INIT) |=>
            (r_bank_select == '0 && !r_irq_enabled && r_irq_count == '0
             && r_mirror == $past(r_mirror)))
        else $error("init did not restore defaults");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_process |=> ($stable(r_irq_count) && $stable(r_bank_select)
                        && $stable(r_irq_enabled)))
        else $error("mapper state changed without a transaction");
`endif

endmodule

[design/bank_switch_mapper_with_scanline_irq_top.sv]
// Path from input transaction to result: input register, then result register.
// Throughput: one item per cycle while results are taken; the result register frees as it is taken.
// Ready stays high while the result register is empty or being drained.
// Reset (i_rst_n, synchronous, low): channels empty, bank count 2, banks {0,1,2,3},
// pattern banks 0..7, vertical mirroring, IRQ state cleared.
module bank_switch_mapper_with_scanline_irq_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bsm_pkg::BYTE_W-1:0] i_cfg_data,
    bsm_item_if.sink                   i_item,
    bsm_result_if.source               o_result
);

    logic             r_in_valid;
    bsm_pkg::t_item   r_in;
    logic             r_out_valid;
    bsm_pkg::t_result r_out;
    bsm_pkg::t_result core_result;
    logic             advance;
    logic             process;

    assign advance      = !r_out_valid || o_result.ready;
    assign process      = advance && r_in_valid;
    assign i_item.ready = !r_in_valid || advance;

    bsm_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_process  (process),
        .i_item     (r_in),
        .o_result   (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.opcode    <= i_item.opcode;
            r_in.address   <= i_item.address;
            r_in.data      <= i_item.data;
            r_in.in_vblank <= i_item.in_vblank;
        end
        if (process) begin
            r_out <= core_result;
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.prg_banks         = r_out.prg_banks;
    assign o_result.chr_banks         = r_out.chr_banks;
    assign o_result.mirror_horizontal = r_out.mirror_horizontal;
    assign o_result.irq_pulse         = r_out.irq_pulse;

endmodule

[bench/tb.sv]
// Testbench for bank_switch_mapper_with_scanline_irq_top: directed and random
// CPU writes, scanline ticks and inits, checked against a bank/IRQ predictor.
// Depends on bsm_pkg, bsm_if and the mapper top level.
module tb;
    import bsm_pkg::*;

    localparam logic [1:0]        OP_UNUSED   = 2'd3;
    localparam logic [BYTE_W-1:0] SEL_UNUSED  = 8'h40;
    localparam int                HOLD_CYCLES = 60;
    localparam int                PHASE_ITEMS = 160;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    logic [BYTE_W-1:0]   cfg_data;

    bsm_item_if   item_ch ();
    bsm_result_if result_ch ();

    bank_switch_mapper_with_scanline_irq_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_item     (item_ch.sink),
        .o_result   (result_ch.source)
    );

    // predicted mapper state
    logic [BYTE_W-1:0] bank_count;
    logic [BYTE_W-1:0] bank_sel;
    logic [BYTE_W-1:0] prg_map [PRG_SLOTS];
    logic [BYTE_W-1:0] chr_map [CHR_SLOTS];
    logic              mirror_h;
    logic              irq_on;
    logic [BYTE_W-1:0] irq_cnt;
    logic [BYTE_W-1:0] irq_latch;

    t_result expected_maps [$];

    int  error_count   = 0;
    int  sent_count    = 0;
    int  checked_count = 0;
    int  pulse_count   = 0;
    int  setting_count = 0;
    int  burst_left    = 0;
    bit  hold_request  = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("Timeout with %0d results outstanding", expected_maps.size());
        $display("bank_switch_mapper_with_scanline_irq_top test failed");
        $finish;
    end

    task automatic load_default_banks();
        logic [BYTE_W-1:0] last;
        last = {bank_count[6:0], 1'b0} - 8'd1;
        bank_sel   = '0;
        prg_map[0] = 8'd0;
        prg_map[1] = 8'd1;
        prg_map[2] = last - 8'd1;
        prg_map[3] = last;
        for (int i = 0; i < CHR_SLOTS; i++) chr_map[i] = BYTE_W'(i);
        irq_on    = 1'b0;
        irq_cnt   = '0;
        irq_latch = '0;
    endtask

    task automatic set_chr_pair(input logic [2:0] first, input logic [BYTE_W-1:0] v);
        chr_map[first]        = v & PAIR_MASK;
        chr_map[first + 3'd1] = (v & PAIR_MASK) + 8'd1;
    endtask

    task automatic steer_bank_data(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] sel;
        sel = bank_sel & SEL_MASK;
        if (sel == SEL_CHR_PAIR0) set_chr_pair(3'd0, v);
        else if (sel == SEL_CHR_PAIR1) set_chr_pair(3'd2, v);
        else if (sel >= SEL_CHR_LO && sel <= SEL_CHR_HI) chr_map[3'(sel + 8'd2)] = v;
        else if (sel == SEL_PRG0) prg_map[0] = v;
        else if (sel == SEL_PRG1) prg_map[1] = v;
        else if (sel == SEL_PRG2) prg_map[2] = v;
        else if (sel == SEL_PRG3) prg_map[3] = v;
        else if (sel == SEL_CHR_PAIR2) set_chr_pair(3'd4, v);
        else if (sel == SEL_CHR_PAIR3) set_chr_pair(3'd6, v);
        else if (sel >= SEL_CHR_ALT_LO && sel <= SEL_CHR_ALT_HI)
            chr_map[3'(sel - SEL_CHR_ALT_LO)] = v;
    endtask

    // apply one accepted item to the predicted state and queue the bank map it yields
    task automatic map_item(input t_item it);
        t_result r;
        r.irq_pulse = 1'b0;
        case (it.opcode)
            OP_CPU_WRITE: begin
                case (it.address & ADDR_MASK)
                    ADDR_BANK_SELECT: bank_sel = it.data;
                    ADDR_BANK_DATA:   steer_bank_data(it.data);
                    ADDR_MIRROR:      mirror_h = it.data[0];
                    ADDR_IRQ_COUNT:   irq_cnt = it.data;
                    ADDR_IRQ_LATCH:   irq_latch = it.data;
                    ADDR_IRQ_DISABLE: irq_on = 1'b0;
                    ADDR_IRQ_ENABLE:  irq_on = 1'b1;
                    default: ;
                endcase
            end
            OP_TICK: begin
                if (!it.in_vblank && irq_on) begin
                    if (irq_cnt == 0) begin
                        irq_cnt     = irq_latch;
                        r.irq_pulse = 1'b1;
                    end else begin
                        irq_cnt = irq_cnt - 8'd1;
                    end
                end
            end
            OP_INIT: load_default_banks();
            default: ;
        endcase
        for (int i = 0; i < PRG_SLOTS; i++) r.prg_banks[i*BYTE_W +: BYTE_W] = prg_map[i];
        for (int i = 0; i < CHR_SLOTS; i++) r.chr_banks[i*BYTE_W +: BYTE_W] = chr_map[i];
        r.mirror_horizontal = mirror_h;
        expected_maps.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s at result %0d: got %h, expected %h",
                 what, checked_count, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (expected_maps.size() == 0) begin
                report_mismatch("unexpected result", 64'(result_ch.prg_banks), '0);
            end else begin
                want = expected_maps.pop_front();
                if (result_ch.prg_banks !== want.prg_banks)
                    report_mismatch("prg_banks", 64'(result_ch.prg_banks),
                                    64'(want.prg_banks));
                if (result_ch.chr_banks !== want.chr_banks)
                    report_mismatch("chr_banks", result_ch.chr_banks, want.chr_banks);
                if (result_ch.mirror_horizontal !== want.mirror_horizontal)
                    report_mismatch("mirror_horizontal", 64'(result_ch.mirror_horizontal),
                                    64'(want.mirror_horizontal));
                if (result_ch.irq_pulse !== want.irq_pulse)
                    report_mismatch("irq_pulse", 64'(result_ch.irq_pulse),
                                    64'(want.irq_pulse));
                if (want.irq_pulse) pulse_count++;
            end
            checked_count++;
        end
    end

    // result side: random stall modes, plus a long hold-off on request
    initial begin : result_sink
        int mode = 0;
        int span = 0;
        int phase = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_request = 0;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(20, 80);
                end
                span--;
                phase++;
                case (mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: result_ch.ready <= ((phase % 5) < 2);
                endcase
            end
        end
    end

    task automatic send_item(input t_item it);
        item_ch.valid     <= 1'b1;
        item_ch.opcode    <= it.opcode;
        item_ch.address   <= it.address;
        item_ch.data      <= it.data;
        item_ch.in_vblank <= it.in_vblank;
        do @(posedge i_clk); while (!item_ch.ready);
        map_item(it);
        sent_count++;
    endtask

    // bursts of random length separated by random gaps
    task automatic pace();
        int gap;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                       : $urandom_range(1, 10);
        end
    endtask

    task automatic send_paced(input t_item it);
        send_item(it);
        pace();
    endtask

    function automatic t_item cpu_write(input logic [ADDR_W-1:0] decode,
                                        input logic [BYTE_W-1:0] value);
        t_item it;
        it.opcode    = OP_CPU_WRITE;
        it.address   = (ADDR_W'($urandom) & ~ADDR_MASK) | decode;
        it.data      = value;
        it.in_vblank = 1'($urandom);
        return it;
    endfunction

    function automatic t_item scan_tick(input logic vblank);
        t_item it;
        it.opcode    = OP_TICK;
        it.address   = ADDR_W'($urandom);
        it.data      = BYTE_W'($urandom);
        it.in_vblank = vblank;
        return it;
    endfunction

    function automatic t_item other_item(input logic [1:0] op);
        t_item it;
        it.opcode    = op;
        it.address   = ADDR_W'($urandom);
        it.data      = BYTE_W'($urandom);
        it.in_vblank = 1'($urandom);
        return it;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_decode(input int k);
        case (k)
            0:       return ADDR_BANK_SELECT;
            1:       return ADDR_BANK_DATA;
            2:       return ADDR_MIRROR;
            3:       return ADDR_IRQ_COUNT;
            4:       return ADDR_IRQ_LATCH;
            5:       return ADDR_IRQ_DISABLE;
            6:       return ADDR_IRQ_ENABLE;
            default: return ADDR_MIRROR | 16'h0001;
        endcase
    endfunction

    // mostly a selector that steers somewhere, with random don't-care bits; else a random byte
    function automatic logic [BYTE_W-1:0] pick_selector();
        logic [BYTE_W-1:0] sel;
        case ($urandom_range(0, 10))
            0:       sel = SEL_CHR_PAIR0;
            1:       sel = SEL_CHR_PAIR1;
            2:       sel = BYTE_W'($urandom_range(SEL_CHR_LO, SEL_CHR_HI));
            3:       sel = SEL_PRG0;
            4:       sel = SEL_PRG1;
            5:       sel = SEL_PRG2;
            6:       sel = SEL_PRG3;
            7:       sel = SEL_CHR_PAIR2;
            8:       sel = SEL_CHR_PAIR3;
            9:       sel = BYTE_W'($urandom_range(SEL_CHR_ALT_LO, SEL_CHR_ALT_HI));
            default: return BYTE_W'($urandom);
        endcase
        return sel | (BYTE_W'($urandom) & ~SEL_MASK);
    endfunction

    function automatic t_item random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            pick = $urandom_range(0, 7);
            if (pick == 0) return cpu_write(ADDR_BANK_SELECT, pick_selector());
            return cpu_write(pick_decode(pick), BYTE_W'($urandom));
        end
        if (pick < 70) return scan_tick($urandom_range(0, 3) == 0);
        if (pick < 75) return other_item(OP_INIT);
        if (pick < 80) return other_item(OP_UNUSED);
        if (pick < 90) begin
            random_item = other_item(OP_CPU_WRITE);
            random_item.address = ADDR_W'($urandom_range(0, 16'h7FFF));
            return random_item;
        end
        return other_item(OP_CPU_WRITE);
    endfunction

    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_maps.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_bank_count(input logic [BYTE_W-1:0] v);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we     <= 1'b0;
        bank_count = v;
        setting_count++;
    endtask

    task automatic select_and_write(input logic [BYTE_W-1:0] sel,
                                    input logic [BYTE_W-1:0] value);
        send_item(cpu_write(ADDR_BANK_SELECT, sel));
        send_item(cpu_write(ADDR_BANK_DATA, value));
    endtask

    task automatic test_ignored_writes();
        t_item it;
        send_item(other_item(OP_UNUSED));
        it = cpu_write(ADDR_BANK_DATA, 8'hFF);
        it.address = 16'h7FFF;
        send_item(it);
        send_item(cpu_write(ADDR_MIRROR | 16'h0001, 8'hFF));
    endtask

    task automatic test_bank_steering();
        select_and_write(SEL_CHR_PAIR0, 8'hFF);
        select_and_write(SEL_CHR_PAIR3 | 8'h38, 8'hFF);
        select_and_write(SEL_PRG2, 8'h00);
        select_and_write(SEL_CHR_ALT_LO + 8'd2, 8'hA5);
        select_and_write(SEL_UNUSED, 8'h55);
    endtask

    task automatic test_mirroring();
        send_item(cpu_write(ADDR_MIRROR, 8'hFF));
    endtask

    task automatic test_scanline_irq();
        send_item(cpu_write(ADDR_IRQ_LATCH, 8'd1));
        send_item(cpu_write(ADDR_IRQ_COUNT, 8'd0));
        send_item(cpu_write(ADDR_IRQ_ENABLE, 8'h00));
        send_item(scan_tick(1'b0));     // counter at zero: reload and pulse
        send_item(scan_tick(1'b1));     // vblank tick is ignored
        send_item(scan_tick(1'b0));
        send_item(scan_tick(1'b0));
        send_item(cpu_write(ADDR_IRQ_DISABLE, 8'hFF));
        send_item(scan_tick(1'b0));
    endtask

    // default last banks follow the bank count, including the 8-bit wrap
    task automatic test_bank_count_defaults();
        write_bank_count(8'd1);
        send_item(other_item(OP_INIT));
        write_bank_count(8'd0);
        send_item(other_item(OP_INIT));
    endtask

    task automatic test_backpressure();
        wait_idle();
        hold_request = 1;
        do @(posedge i_clk); while (result_ch.ready);
        repeat (24) send_item(random_item());
    endtask

    task automatic test_random_traffic();
        logic [BYTE_W-1:0] counts [5];
        int                stop_at;
        int                n;
        counts = '{8'd128, 8'd1, BYTE_W'($urandom_range(3, 127)), 8'd255, 8'd2};
        for (int p = 0; p < 5; p++) begin
            write_bank_count(counts[p]);
            send_paced(other_item(OP_INIT));
            stop_at = sent_count + PHASE_ITEMS;
            while (sent_count < stop_at) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        send_paced(cpu_write(ADDR_BANK_SELECT, pick_selector()));
                        send_paced(cpu_write(ADDR_BANK_DATA, BYTE_W'($urandom)));
                    end
                    3, 4: begin
                        if ($urandom_range(0, 3) == 0)
                            send_paced(cpu_write(ADDR_IRQ_LATCH, BYTE_W'($urandom)));
                        else
                            send_paced(cpu_write(ADDR_IRQ_LATCH, BYTE_W'($urandom_range(0, 4))));
                        send_paced(cpu_write(ADDR_IRQ_COUNT, BYTE_W'($urandom_range(0, 4))));
                        send_paced(cpu_write(ADDR_IRQ_ENABLE, BYTE_W'($urandom)));
                        n = $urandom_range(2, 10);
                        repeat (n) send_paced(scan_tick($urandom_range(0, 9) == 0));
                    end
                    default: send_paced(random_item());
                endcase
            end
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_data          <= '0;
        item_ch.valid     <= 1'b0;
        item_ch.opcode    <= OP_CPU_WRITE;
        item_ch.address   <= '0;
        item_ch.data      <= '0;
        item_ch.in_vblank <= 1'b0;
        bank_count = PRG_ROM_BANKS_RESET;
        mirror_h   = 1'b0;
        load_default_banks();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ignored_writes();
        test_bank_steering();
        test_mirroring();
        test_scanline_irq();
        test_bank_count_defaults();
        test_backpressure();
        test_random_traffic();

        item_ch.valid <= 1'b0;
        while (expected_maps.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);

        $display("Covered %0d items, %0d checked bank maps, %0d scanline interrupts,",
                 sent_count, checked_count, pulse_count);
        $display("across %0d bank count settings with stalls on both channels.",
                 setting_count);
        if (error_count == 0 && expected_maps.size() == 0) begin
            $display("bank_switch_mapper_with_scanline_irq_top test passed");
        end else begin
            $display("bank_switch_mapper_with_scanline_irq_top test failed");
        end
        $finish;
    end

endmodule
